// File: hdl/pfe_pkg.sv
// Shared types, codes and the per-entry fade step function of the palette fade engine.
package pfe_pkg;

    localparam int DEF_ENTRIES    = 64;
    localparam int DEF_FADE_STEPS = 22;
    localparam int DEF_STEP_SIZE  = 32;

    localparam logic [7:0] WHITE_LEVEL = 8'd224;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_FADE_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ENTRY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_M1    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SINGLE_BANK = 2'd3;

    localparam logic [2:0] MODE_NONE      = 3'd0;
    localparam logic [2:0] MODE_FADE_IN   = 3'd1;
    localparam logic [2:0] MODE_FADE_OUT  = 3'd2;
    localparam logic [2:0] MODE_FLASH_IN  = 3'd3;
    localparam logic [2:0] MODE_FLASH_OUT = 3'd4;

    localparam logic [1:0] FUNC_BEGIN = 2'd0;
    localparam logic [1:0] FUNC_TICK  = 2'd1;
    localparam logic [1:0] FUNC_LOAD  = 2'd2;
    localparam logic [1:0] FUNC_READ  = 2'd3;

    localparam logic [1:0] WR_ZERO  = 2'd0;
    localparam logic [1:0] WR_WHITE = 2'd1;
    localparam logic [1:0] WR_STEP  = 2'd2;

    localparam logic [1:0] OUT_ZERO = 2'd0;
    localparam logic [1:0] OUT_TICK = 2'd1;
    localparam logic [1:0] OUT_READ = 2'd2;

    typedef struct packed {
        logic [1:0] func;
        logic       bank;
        logic [5:0] index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_in_word;

    typedef struct packed {
        logic       done_res;
        logic [7:0] cur_red;
        logic [7:0] cur_green;
        logic [7:0] cur_blue;
    } t_out_word;

    typedef struct packed {
        logic       cap_item;
        logic       cnt_clear;
        logic       cnt_step;
        logic       tgt_we;
        logic       rd_en;
        logic       rd_item;
        logic       wr_en;
        logic [1:0] wr_sel;
        logic       out_load;
        logic [1:0] out_sel;
    } t_cmd;

    typedef struct packed {
        logic [1:0] func;
        logic [2:0] mode;
        logic       single_bank;
    } t_status;

    function automatic logic mode_active(input logic [2:0] mode);
        return (mode == MODE_FADE_IN) || (mode == MODE_FADE_OUT) ||
               (mode == MODE_FLASH_IN) || (mode == MODE_FLASH_OUT);
    endfunction

    function automatic logic [23:0] step_color(input logic [2:0]  mode,
                                               input logic [23:0] cur,
                                               input logic [23:0] tgt,
                                               input logic [7:0]  step);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] tr;
        logic [7:0] tg;
        logic [7:0] tb;
        r  = cur[23:16];
        g  = cur[15:8];
        b  = cur[7:0];
        tr = tgt[23:16];
        tg = tgt[15:8];
        tb = tgt[7:0];
        case (mode)
            MODE_FADE_IN: begin
                if (tb > b)      b = b + step;
                else if (tg > g) g = g + step;
                else if (tr > r) r = r + step;
            end
            MODE_FADE_OUT: begin
                if (r != 8'd0)      r = r - step;
                else if (g != 8'd0) g = g - step;
                else if (b != 8'd0) b = b - step;
            end
            MODE_FLASH_IN: begin
                if (tb < b)      b = b - step;
                else if (tg < g) g = g - step;
                else if (tr < r) r = r - step;
            end
            default: begin
                if (r != WHITE_LEVEL)      r = r + step;
                else if (g != WHITE_LEVEL) g = g + step;
                else if (b != WHITE_LEVEL) b = b + step;
            end
        endcase
        return {r, g, b};
    endfunction

endpackage

// File: hdl/pfe_dp.sv
// Datapath: configuration registers, palette memories, step counter and result register.
module pfe_dp
    import pfe_pkg::*;
#(
    parameter int ENTRIES    = DEF_ENTRIES,
    parameter int FADE_STEPS = DEF_FADE_STEPS,
    parameter int STEP_SIZE  = DEF_STEP_SIZE,
    localparam int EW        = $clog2(ENTRIES),
    localparam int AW        = EW + 1,
    localparam int RW        = ((EW + 1) > 7) ? (EW + 1) : 7
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_in_word              i_in_word,
    input  t_cmd                  i_cmd,
    input  logic [AW-1:0]         i_sweep_addr,
    input  logic [AW-1:0]         i_wr_addr,
    output t_status               o_status,
    output logic [RW-1:0]         o_lo,
    output logic [RW-1:0]         o_hi,
    output t_out_word             o_out_word
);

    localparam int MEM_DEPTH = 2 ** AW;
    localparam int CW        = $clog2(FADE_STEPS);

    logic [2:0]    r_fade_mode;
    logic [5:0]    r_first_entry;
    logic [5:0]    r_count_m1;
    logic          r_single_bank;
    t_in_word      r_item;
    logic [23:0]   cur_mem [MEM_DEPTH];
    logic [23:0]   tgt_mem [MEM_DEPTH];
    logic [23:0]   r_cur_q;
    logic [23:0]   r_tgt_q;
    logic [CW-1:0] r_step_cnt;
    logic          r_tick_done;
    t_out_word     r_out;

    logic [RW-1:0] ent_lim;
    logic [RW-1:0] range_end;
    logic [RW-1:0] item_ext;
    logic          idx_ok;
    logic [AW-1:0] item_addr;
    logic [AW-1:0] rd_addr;
    logic [23:0]   wr_data;
    logic [CW:0]   cnt_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fade_mode   <= MODE_NONE;
            r_first_entry <= 6'd0;
            r_count_m1    <= 6'd63;
            r_single_bank <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FADE_MODE:   r_fade_mode   <= i_cfg_data[2:0];
                CFG_FIRST_ENTRY: r_first_entry <= i_cfg_data[5:0];
                CFG_COUNT_M1:    r_count_m1    <= i_cfg_data[5:0];
                CFG_SINGLE_BANK: r_single_bank <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_item) begin
            r_item <= i_in_word;
        end
    end

    assign ent_lim   = RW'(ENTRIES);
    assign range_end = RW'(r_first_entry) + RW'(r_count_m1) + RW'(1);

    always_comb begin
        if (r_fade_mode == MODE_FADE_IN) begin
            o_lo = RW'(r_first_entry);
            o_hi = (range_end > ent_lim) ? ent_lim : range_end;
        end else begin
            o_lo = '0;
            o_hi = ent_lim;
        end
    end

    assign item_ext  = RW'(r_item.index);
    assign idx_ok    = item_ext < ent_lim;
    assign item_addr = {r_item.bank, item_ext[EW-1:0]};
    assign rd_addr   = i_cmd.rd_item ? item_addr : i_sweep_addr;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_cur_q <= cur_mem[rd_addr];
            r_tgt_q <= tgt_mem[rd_addr];
        end
    end

    always_comb begin
        case (i_cmd.wr_sel)
            WR_ZERO:  wr_data = 24'd0;
            WR_WHITE: wr_data = {WHITE_LEVEL, WHITE_LEVEL, WHITE_LEVEL};
            WR_STEP:  wr_data = step_color(r_fade_mode, r_cur_q, r_tgt_q, 8'(STEP_SIZE));
            default:  wr_data = 24'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            cur_mem[i_wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tgt_we && idx_ok) begin
            tgt_mem[item_addr] <= {r_item.red, r_item.green, r_item.blue};
        end
    end

    assign cnt_next = {1'b0, r_step_cnt} + (CW + 1)'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_cnt  <= '0;
            r_tick_done <= 1'b0;
        end else if (i_cmd.cnt_clear) begin
            r_step_cnt <= '0;
        end else if (i_cmd.cnt_step) begin
            if (!mode_active(r_fade_mode)) begin
                r_tick_done <= 1'b1;
            end else if (cnt_next >= (CW + 1)'(FADE_STEPS)) begin
                r_step_cnt  <= '0;
                r_tick_done <= 1'b1;
            end else begin
                r_step_cnt  <= cnt_next[CW-1:0];
                r_tick_done <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            case (i_cmd.out_sel)
                OUT_TICK: r_out <= {r_tick_done, 24'd0};
                OUT_READ: r_out <= {1'b0, (idx_ok ? r_cur_q : 24'd0)};
                default:  r_out <= '0;
            endcase
        end
    end

    assign o_status.func        = r_item.func;
    assign o_status.mode        = r_fade_mode;
    assign o_status.single_bank = r_single_bank;
    assign o_out_word           = r_out;

endmodule

// File: hdl/pfe_ctrl.sv
// Controller: item sequencing, palette sweep counters and output handshake.
module pfe_ctrl
    import pfe_pkg::*;
#(
    parameter int ENTRIES = DEF_ENTRIES,
    localparam int EW     = $clog2(ENTRIES),
    localparam int AW     = EW + 1,
    localparam int RW     = ((EW + 1) > 7) ? (EW + 1) : 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  t_status       i_status,
    input  logic [RW-1:0] i_lo,
    input  logic [RW-1:0] i_hi,
    output t_cmd          o_cmd,
    output logic [AW-1:0] o_sweep_addr,
    output logic [AW-1:0] o_wr_addr
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_DISPATCH = 3'd1;
    localparam logic [2:0] ST_SWEEP    = 3'd2;
    localparam logic [2:0] ST_DRAIN    = 3'd3;
    localparam logic [2:0] ST_READ     = 3'd4;
    localparam logic [2:0] ST_FINISH   = 3'd5;

    logic [2:0]    r_state,     n_state;
    logic          r_bank,      n_bank;
    logic [RW-1:0] r_entry,     n_entry;
    logic          r_two_banks, n_two_banks;
    logic          r_clearing,  n_clearing;
    logic [1:0]    r_wsel,      n_wsel;
    logic [1:0]    r_osel,      n_osel;
    logic          r_out_valid, n_out_valid;
    logic          r_pend;
    logic [AW-1:0] r_paddr;

    logic [RW-1:0] s_lo;
    logic [RW-1:0] s_hi;
    logic [RW-1:0] entry_inc;
    logic          in_mode;

    assign s_lo      = r_clearing ? '0 : i_lo;
    assign s_hi      = r_clearing ? RW'(ENTRIES) : i_hi;
    assign entry_inc = r_entry + RW'(1);
    assign in_mode   = (i_status.mode == MODE_FADE_IN) || (i_status.mode == MODE_FLASH_IN);

    assign o_sweep_addr = {r_bank, r_entry[EW-1:0]};
    assign o_wr_addr    = r_paddr;
    assign o_in_ready   = (r_state == ST_IDLE);
    assign o_out_valid  = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_bank      = r_bank;
        n_entry     = r_entry;
        n_two_banks = r_two_banks;
        n_clearing  = r_clearing;
        n_wsel      = r_wsel;
        n_osel      = r_osel;
        o_cmd       = '0;
        o_cmd.wr_en  = r_pend;
        o_cmd.wr_sel = r_wsel;
        o_cmd.out_sel = r_osel;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap_item = 1'b1;
                    n_state        = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                n_osel  = OUT_ZERO;
                n_state = ST_FINISH;
                n_bank  = 1'b0;
                n_entry = i_lo;
                case (i_status.func)
                    FUNC_BEGIN: begin
                        o_cmd.cnt_clear = mode_active(i_status.mode);
                        n_two_banks     = 1'b0;
                        n_wsel = (i_status.mode == MODE_FADE_IN) ? WR_ZERO : WR_WHITE;
                        if (in_mode && (i_lo < i_hi)) begin
                            n_state = ST_SWEEP;
                        end
                    end
                    FUNC_TICK: begin
                        o_cmd.cnt_step = 1'b1;
                        n_osel         = OUT_TICK;
                        n_wsel         = WR_STEP;
                        n_two_banks    = !(in_mode && i_status.single_bank);
                        if (mode_active(i_status.mode) && (i_lo < i_hi)) begin
                            n_state = ST_SWEEP;
                        end
                    end
                    FUNC_LOAD: begin
                        o_cmd.tgt_we = 1'b1;
                    end
                    FUNC_READ: begin
                        o_cmd.rd_en   = 1'b1;
                        o_cmd.rd_item = 1'b1;
                        n_osel        = OUT_READ;
                        n_state       = ST_READ;
                    end
                    default: ;
                endcase
            end
            ST_SWEEP: begin
                o_cmd.rd_en = 1'b1;
                if (entry_inc >= s_hi) begin
                    if (!r_bank && r_two_banks) begin
                        n_bank  = 1'b1;
                        n_entry = s_lo;
                    end else begin
                        n_state = ST_DRAIN;
                    end
                end else begin
                    n_entry = entry_inc;
                end
            end
            ST_DRAIN: begin
                n_state    = r_clearing ? ST_IDLE : ST_FINISH;
                n_clearing = 1'b0;
            end
            ST_READ: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_SWEEP;
            r_bank      <= 1'b0;
            r_entry     <= '0;
            r_two_banks <= 1'b1;
            r_clearing  <= 1'b1;
            r_wsel      <= WR_ZERO;
            r_osel      <= OUT_ZERO;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bank      <= n_bank;
            r_entry     <= n_entry;
            r_two_banks <= n_two_banks;
            r_clearing  <= n_clearing;
            r_wsel      <= n_wsel;
            r_osel      <= n_osel;
            r_out_valid <= n_out_valid;
            r_pend      <= (r_state == ST_SWEEP);
        end
    end

    always_ff @(posedge i_clk) begin
        r_paddr <= o_sweep_addr;
    end

endmodule

// File: hdl/palette_fade_engine_unit.sv
// Top level of the palette fade engine: controller, datapath and checks.
//
// Input words arrive on a valid/ready channel and each produces exactly one
// output word on a second valid/ready channel. Configuration registers are
// written through a plain write port and should change only while idle.
// A load or a begin without a sweep goes from dispatch straight to the finish
// state, a read passes a read state in between. A tick sweeps every covered
// entry through the read port and the separate write port of the current
// palette memory, one entry per cycle, so its output word waits for the whole
// sweep and then passes the drain and finish states. A fade-in or flash-in
// begin sweeps its bank 0 range at the same rate. One word is in work at a
// time, and the next word is taken in the cycle after the output register
// loads. After reset the block clears both current palette banks, one entry
// per cycle, and first raises ready once that pass has drained.
// Configuration writes are taken during that pass. The result sits in an
// output register, so the next word is accepted while the receiver stalls;
// the block then holds that next result until the register is free.
module palette_fade_engine_unit
    import pfe_pkg::*;
#(
    parameter int ENTRIES    = DEF_ENTRIES,
    parameter int FADE_STEPS = DEF_FADE_STEPS,
    parameter int STEP_SIZE  = DEF_STEP_SIZE
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_word              i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_word             o_out_word
);

    localparam int EW = $clog2(ENTRIES);
    localparam int AW = EW + 1;
    localparam int RW = ((EW + 1) > 7) ? (EW + 1) : 7;

    t_cmd          cmd;
    t_status       status;
    logic [RW-1:0] range_lo;
    logic [RW-1:0] range_hi;
    logic [AW-1:0] sweep_addr;
    logic [AW-1:0] wr_addr;

    pfe_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_status     (status),
        .i_lo         (range_lo),
        .i_hi         (range_hi),
        .o_cmd        (cmd),
        .o_sweep_addr (sweep_addr),
        .o_wr_addr    (wr_addr)
    );

    pfe_dp #(
        .ENTRIES    (ENTRIES),
        .FADE_STEPS (FADE_STEPS),
        .STEP_SIZE  (STEP_SIZE)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_word    (i_in_word),
        .i_cmd        (cmd),
        .i_sweep_addr (sweep_addr),
        .i_wr_addr    (wr_addr),
        .o_status     (status),
        .o_lo         (range_lo),
        .o_hi         (range_hi),
        .o_out_word   (o_out_word)
    );

    ap_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_out_valid || i_out_ready))
        else $error("Result register loaded while a word is still waiting.");

    ap_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("Second word accepted while one is in work.");

    ap_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !cmd.wr_en)
        else $error("Palette write pending while the block is idle.");

endmodule

// File: dv/pfe_fade_checker.sv
// Checker for the palette fade engine: predicts each output word and compares it.
module pfe_fade_checker
    import pfe_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  t_in_word              i_in_word,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  t_out_word             i_out_word,
    output int                    o_errors,
    output int                    o_pending,
    output int                    o_done_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES = DEF_ENTRIES;

    logic [23:0] live_pal [2][ENTRIES];
    logic [23:0] goal_pal [2][ENTRIES];
    logic [4:0]  step_cnt;
    logic [2:0]  mode_r;
    logic [5:0]  first_r;
    logic [5:0]  cm1_r;
    logic        single_r;

    t_out_word predicted_words [$];
    int        err_cnt = 0;
    int        done_cnt = 0;

    function automatic logic [23:0] advance_entry(input logic [2:0]  mode,
                                                  input logic [23:0] now,
                                                  input logic [23:0] goal);
        logic [7:0] chan [3];
        logic [7:0] aim  [3];
        logic       moved;
        int         c;
        for (int k = 0; k < 3; k++) begin
            chan[k] = now[23 - 8*k -: 8];
            aim[k]  = goal[23 - 8*k -: 8];
        end
        moved = 1'b0;
        for (int k = 0; k < 3 && !moved; k++) begin
            c = (mode == MODE_FADE_IN || mode == MODE_FLASH_IN) ? 2 - k : k;
            case (mode)
                MODE_FADE_IN: begin
                    moved = aim[c] > chan[c];
                    if (moved) chan[c] = chan[c] + 8'(DEF_STEP_SIZE);
                end
                MODE_FLASH_IN: begin
                    moved = aim[c] < chan[c];
                    if (moved) chan[c] = chan[c] - 8'(DEF_STEP_SIZE);
                end
                MODE_FADE_OUT: begin
                    moved = chan[c] != 8'd0;
                    if (moved) chan[c] = chan[c] - 8'(DEF_STEP_SIZE);
                end
                default: begin
                    moved = chan[c] != WHITE_LEVEL;
                    if (moved) chan[c] = chan[c] + 8'(DEF_STEP_SIZE);
                end
            endcase
        end
        return {chan[0], chan[1], chan[2]};
    endfunction

    function automatic t_out_word apply_word(input t_in_word w);
        t_out_word res;
        int        lo;
        int        hi;
        int        nb;
        logic      fading;
        res    = '0;
        lo     = 0;
        hi     = ENTRIES;
        fading = (mode_r >= MODE_FADE_IN) && (mode_r <= MODE_FLASH_OUT);
        if (mode_r == MODE_FADE_IN) begin
            lo = int'(first_r);
            hi = int'(first_r) + int'(cm1_r) + 1;
            if (hi > ENTRIES) hi = ENTRIES;
        end
        case (w.func)
            FUNC_BEGIN: begin
                if (mode_r == MODE_FADE_IN) begin
                    for (int e = lo; e < hi; e++) live_pal[0][e] = '0;
                end else if (mode_r == MODE_FLASH_IN) begin
                    for (int e = 0; e < ENTRIES; e++) live_pal[0][e] = {3{WHITE_LEVEL}};
                end
                if (fading) step_cnt = '0;
            end
            FUNC_TICK: begin
                if (!fading) begin
                    res.done_res = 1'b1;
                end else begin
                    nb = ((mode_r == MODE_FADE_IN || mode_r == MODE_FLASH_IN) && single_r)
                         ? 1 : 2;
                    for (int b = 0; b < nb; b++) begin
                        for (int e = lo; e < hi; e++) begin
                            live_pal[b][e] = advance_entry(mode_r, live_pal[b][e],
                                                           goal_pal[b][e]);
                        end
                    end
                    if (int'(step_cnt) + 1 >= DEF_FADE_STEPS) begin
                        step_cnt     = '0;
                        res.done_res = 1'b1;
                    end else begin
                        step_cnt = step_cnt + 5'd1;
                    end
                end
            end
            FUNC_LOAD: begin
                goal_pal[w.bank][w.index] = {w.red, w.green, w.blue};
            end
            default: begin
                {res.cur_red, res.cur_green, res.cur_blue} = live_pal[w.bank][w.index];
            end
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            for (int b = 0; b < 2; b++) begin
                for (int e = 0; e < ENTRIES; e++) begin
                    live_pal[b][e] = '0;
                    goal_pal[b][e] = '0;
                end
            end
            step_cnt = '0;
            mode_r   = MODE_NONE;
            first_r  = 6'd0;
            cm1_r    = 6'd63;
            single_r = 1'b0;
            predicted_words.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FADE_MODE:   mode_r   = i_cfg_data[2:0];
                    CFG_FIRST_ENTRY: first_r  = i_cfg_data[5:0];
                    CFG_COUNT_M1:    cm1_r    = i_cfg_data[5:0];
                    default:         single_r = i_cfg_data[0];
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (predicted_words.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10) begin
                        $display("%0t: output word %h arrived with nothing pending",
                                 $realtime, i_out_word);
                    end
                end else begin
                    want = predicted_words.pop_front();
                    if (i_out_word.done_res !== want.done_res ||
                        i_out_word.cur_red !== want.cur_red ||
                        i_out_word.cur_green !== want.cur_green ||
                        i_out_word.cur_blue !== want.cur_blue) begin
                        err_cnt++;
                        if (err_cnt <= 10) begin
                            $display("%0t: mismatch, expected done=%0b rgb=%h/%h/%h, got done=%0b rgb=%h/%h/%h",
                                     $realtime, want.done_res, want.cur_red,
                                     want.cur_green, want.cur_blue, i_out_word.done_res,
                                     i_out_word.cur_red, i_out_word.cur_green,
                                     i_out_word.cur_blue);
                        end
                    end
                    if (i_out_word.done_res === 1'b1) done_cnt++;
                end
            end
            if (i_in_valid && i_in_ready) predicted_words.push_back(apply_word(i_in_word));
        end
        o_pending    <= predicted_words.size();
        o_errors     <= err_cnt;
        o_done_count <= done_cnt;
    end

endmodule

// File: dv/tb_top.sv
// Testbench top for the palette fade engine: clock, reset, stimulus and verdict.
module tb_top;
    import pfe_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS = 850;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 1_000_000;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    t_in_word              in_word  = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_word             out_word;

    int errors;
    int pending;
    int done_count;

    int tx_pct     = 0;
    int rx_pct     = 0;
    int hold_token = 0;
    int hold_seen  = 0;
    int hold_left  = 0;
    int cycles     = 0;
    int words_sent = 0;
    int ticks_sent = 0;
    int setups     = 0;

    logic [2:0] cfg_mode   = MODE_NONE;
    logic [5:0] cfg_first  = 6'd0;
    logic [5:0] cfg_cm1    = 6'd63;
    logic       cfg_single = 1'b0;
    bit         loaded [2][DEF_ENTRIES];

    palette_fade_engine_unit i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    pfe_fade_checker u_fade_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_word   (out_word),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_done_count (done_count)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= !(rx_pct != 0 && $urandom_range(99) < rx_pct);
        end
    end

    task automatic put_word(input logic [1:0] fn, input logic bk, input logic [5:0] ix,
                            input logic [23:0] rgb);
        t_in_word w;
        w.func  = fn;
        w.bank  = bk;
        w.index = ix;
        {w.red, w.green, w.blue} = rgb;
        while (tx_pct != 0 && $urandom_range(99) < tx_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        words_sent++;
        if (fn == FUNC_TICK) ticks_sent++;
    endtask

    task automatic store_target(input logic bk, input logic [5:0] ix, input logic [23:0] rgb);
        put_word(FUNC_LOAD, bk, ix, rgb);
        loaded[bk][ix] = 1'b1;
    endtask

    task automatic random_word();
        logic [1:0] fn;
        logic       bk;
        logic [5:0] ix;
        fn = 2'($urandom_range(3));
        bk = 1'($urandom_range(1));
        ix = 6'($urandom_range(63));
        put_word(fn, bk, ix, 24'($urandom));
        if (fn == FUNC_LOAD) loaded[bk][ix] = 1'b1;
    endtask

    // Fade-in and flash-in steps compare against targets, so every covered target
    // entry gets loaded before the first tick of such a setup.
    task automatic cover_targets();
        int lo;
        int hi;
        int nb;
        if (cfg_mode != MODE_FADE_IN && cfg_mode != MODE_FLASH_IN) return;
        lo = 0;
        hi = DEF_ENTRIES;
        if (cfg_mode == MODE_FADE_IN) begin
            lo = int'(cfg_first);
            hi = int'(cfg_first) + int'(cfg_cm1) + 1;
            if (hi > DEF_ENTRIES) hi = DEF_ENTRIES;
        end
        nb = cfg_single ? 1 : 2;
        for (int b = 0; b < nb; b++) begin
            for (int e = lo; e < hi; e++) begin
                if (!loaded[b][e]) store_target(1'(b), 6'(e), 24'($urandom));
            end
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(input logic [2:0] m, input logic [5:0] f, input logic [5:0] c,
                              input logic s);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_FADE_MODE;
        cfg_data <= CFG_DATA_W'(m);
        @(posedge clk);
        cfg_idx  <= CFG_FIRST_ENTRY;
        cfg_data <= f;
        @(posedge clk);
        cfg_idx  <= CFG_COUNT_M1;
        cfg_data <= c;
        @(posedge clk);
        cfg_idx  <= CFG_SINGLE_BANK;
        cfg_data <= CFG_DATA_W'(s);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        cfg_mode   = m;
        cfg_first  = f;
        cfg_cm1    = c;
        cfg_single = s;
        setups++;
    endtask

    initial begin
        int         base;
        int         nticks;
        int         phase_no;
        logic [2:0] m;
        logic [5:0] f;
        logic [5:0] c;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset contents, mode none, all four functions at field extremes.
        put_word(FUNC_READ, 1'b0, 6'd0, 24'hffffff);
        put_word(FUNC_READ, 1'b1, 6'd63, 24'h000000);
        put_word(FUNC_TICK, 1'b1, 6'd63, 24'h5a5a5a);
        put_word(FUNC_BEGIN, 1'b0, 6'd0, 24'ha5a5a5);
        store_target(1'b1, 6'd63, 24'hffffff);
        store_target(1'b0, 6'd0, 24'h000000);
        drain();
        set_config(3'd7, 6'd0, 6'd63, 1'b1);
        put_word(FUNC_TICK, 1'b0, 6'd0, 24'h000000);
        // A fade-in range that runs past the last entry.
        drain();
        set_config(MODE_FADE_IN, 6'd62, 6'd63, 1'b0);
        cover_targets();
        put_word(FUNC_BEGIN, 1'b0, 6'd0, 24'h000000);
        put_word(FUNC_TICK, 1'b0, 6'd0, 24'h000000);
        put_word(FUNC_READ, 1'b0, 6'd62, 24'h000000);
        put_word(FUNC_READ, 1'b1, 6'd63, 24'h000000);
        put_word(FUNC_READ, 1'b0, 6'd61, 24'h000000);
        // Single bank has no effect on the out modes.
        drain();
        set_config(MODE_FLASH_OUT, 6'd0, 6'd0, 1'b1);
        put_word(FUNC_BEGIN, 1'b0, 6'd0, 24'h000000);
        put_word(FUNC_TICK, 1'b0, 6'd0, 24'h000000);
        put_word(FUNC_READ, 1'b1, 6'd0, 24'h000000);
        drain();
        set_config(MODE_FADE_OUT, 6'd63, 6'd0, 1'b0);
        put_word(FUNC_BEGIN, 1'b0, 6'd0, 24'h000000);
        put_word(FUNC_TICK, 1'b0, 6'd0, 24'h000000);
        put_word(FUNC_READ, 1'b0, 6'd62, 24'h000000);

        base     = words_sent;
        phase_no = 0;
        while (words_sent < base + RANDOM_WORDS) begin
            drain();
            case ($urandom_range(9))
                0:       m = MODE_NONE;
                1:       m = 3'($urandom_range(5, 7));
                2, 3:    m = MODE_FADE_IN;
                4, 5:    m = MODE_FADE_OUT;
                6, 7:    m = MODE_FLASH_IN;
                default: m = MODE_FLASH_OUT;
            endcase
            case ($urandom_range(3))
                0:       f = 6'd0;
                1:       f = 6'd63;
                default: f = 6'($urandom_range(63));
            endcase
            case ($urandom_range(3))
                0:       c = 6'd0;
                1:       c = 6'd63;
                2:       c = 6'($urandom_range(15));
                default: c = 6'($urandom_range(63));
            endcase
            set_config(m, f, c, 1'($urandom_range(1)));
            case (phase_no % 5)
                1: begin
                    tx_pct = 55;
                    rx_pct <= 0;
                end
                2: begin
                    tx_pct = 0;
                    rx_pct <= 55;
                end
                3: begin
                    tx_pct = 33;
                    rx_pct <= 33;
                end
                default: begin
                    tx_pct = 0;
                    rx_pct <= 0;
                end
            endcase
            if (phase_no == 2) hold_token <= hold_token + 1;
            cover_targets();
            if ($urandom_range(7) != 0) put_word(FUNC_BEGIN, 1'($urandom_range(1)),
                                                 6'($urandom_range(63)), 24'($urandom));
            nticks = ($urandom_range(3) == 0) ? $urandom_range(1, 30) : $urandom_range(22, 24);
            for (int t = 0; t < nticks; t++) begin
                put_word(FUNC_TICK, 1'($urandom_range(1)), 6'($urandom_range(63)),
                         24'($urandom));
                repeat ($urandom_range(2)) begin
                    put_word(FUNC_READ, 1'($urandom_range(1)), 6'($urandom_range(63)),
                             24'($urandom));
                end
                if ($urandom_range(9) == 0) random_word();
            end
            phase_no++;
        end

        drain();
        repeat (20) @(posedge clk);
        $display("Sent %0d words with %0d ticks over %0d register setups; %0d done reports.",
                 words_sent, ticks_sent, setups, done_count);
        $display("Setups mixed every fade mode and unused codes, clipped ranges and both bank modes.");
        if (errors == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
